FILE: design/sabv_pkg.sv
// Shared constants, accumulator type and arctangent table for the signed angle block.
package sabv_pkg;

  localparam int ACC_FRAC   = 30;  // fraction bits of the angle accumulator
  localparam int ZW         = 34;  // accumulator width, holds +-pi and more in Q3.30
  localparam int NORM_TOP   = 47;  // normalize until the larger magnitude reaches 2^47
  localparam int NORM_STEPS = 6;   // shifts of 32, 16, 8, 4, 2 and 1
  localparam int NORM_SPLIT = 3;   // shift steps done in the first normalize stage
  localparam int ATAN_LEN   = 32;

  typedef logic signed [ZW-1:0] angle_acc_t;

  localparam angle_acc_t PI_Q30      = 34'sd3373259426;
  localparam angle_acc_t HALF_PI_Q30 = 34'sd1686629713;

  // atan(2^-idx) in Q3.30
  function automatic angle_acc_t atan_q30(input int idx);
    angle_acc_t val;
    case (idx)
      0:       val = 34'sd843314857;
      1:       val = 34'sd497837830;
      2:       val = 34'sd263043837;
      3:       val = 34'sd133525159;
      4:       val = 34'sd67021687;
      5:       val = 34'sd33543516;
      6:       val = 34'sd16775851;
      7:       val = 34'sd8388437;
      8:       val = 34'sd4194283;
      9:       val = 34'sd2097149;
      10:      val = 34'sd1048576;
      11:      val = 34'sd524288;
      12:      val = 34'sd262144;
      13:      val = 34'sd131072;
      14:      val = 34'sd65536;
      15:      val = 34'sd32768;
      16:      val = 34'sd16384;
      17:      val = 34'sd8192;
      18:      val = 34'sd4096;
      19:      val = 34'sd2048;
      20:      val = 34'sd1024;
      21:      val = 34'sd512;
      22:      val = 34'sd256;
      23:      val = 34'sd128;
      24:      val = 34'sd64;
      25:      val = 34'sd32;
      26:      val = 34'sd16;
      27:      val = 34'sd8;
      28:      val = 34'sd4;
      29:      val = 34'sd2;
      30:      val = 34'sd1;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

FILE: design/signed_angle_between_vectors_top.sv
// Signed angle between two 3D vectors about a reference axis, fully pipelined.
//
// Each item carries vectors a, b and axis n; the result is atan2((a x b) . n, a . b)
// in radians with ANGLE_FRAC_BITS fraction bits, saturated to +-pi, and 0 when both
// arguments are zero. The datapath is one pipeline: products, cross and dot sums,
// triple products and sum, magnitude, two normalize stages, quadrant pre-rotation,
// one stage per CORDIC iteration, then rounding into the output register. It takes
// one item every cycle unless stalled: while the output register holds an item
// that is not taken, the whole pipeline holds and in_ready_o is low.
module signed_angle_between_vectors_top #(
  parameter int COORD_BITS      = 16,
  parameter int ANGLE_FRAC_BITS = 13,
  parameter int CORDIC_STEPS    = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [COORD_BITS-1:0]      first_x_i,
  input  logic signed [COORD_BITS-1:0]      first_y_i,
  input  logic signed [COORD_BITS-1:0]      first_z_i,
  input  logic signed [COORD_BITS-1:0]      second_x_i,
  input  logic signed [COORD_BITS-1:0]      second_y_i,
  input  logic signed [COORD_BITS-1:0]      second_z_i,
  input  logic signed [COORD_BITS-1:0]      ref_axis_x_i,
  input  logic signed [COORD_BITS-1:0]      ref_axis_y_i,
  input  logic signed [COORD_BITS-1:0]      ref_axis_z_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [ANGLE_FRAC_BITS+2:0] signed_angle_o
);
  import sabv_pkg::*;

  localparam int CB  = COORD_BITS;
  localparam int PW  = 2 * CB;        // coordinate product
  localparam int CW  = PW + 1;        // cross product component
  localparam int DW  = PW + 2;        // dot product
  localparam int TPW = CW + CB;       // triple product term
  localparam int TW  = TPW + 2;       // triple product
  localparam int NW  = (TW > NORM_TOP + 1) ? TW : NORM_TOP + 2;
  localparam int XW  = NW + 2;        // CORDIC x/y, room for gain and pre-rotation
  localparam int OW  = ANGLE_FRAC_BITS + 3;
  localparam int SH  = ACC_FRAC - ANGLE_FRAC_BITS;

  localparam angle_acc_t HALF_RND = angle_acc_t'(1) <<< (SH - 1);
  localparam angle_acc_t LIM      = (PI_Q30 + HALF_RND) >>> SH;
  localparam logic signed [OW-1:0] LIM_O = OW'(LIM);

  logic en;

  // ---------------- stage 1: coordinate products
  logic                 s1_v_q;
  logic signed [PW-1:0] p_aybz_q, p_azby_q, p_azbx_q, p_axbz_q, p_axby_q, p_aybx_q;
  logic signed [PW-1:0] p_axbx_q, p_ayby_q, p_azbz_q;
  logic signed [CB-1:0] s1_nx_q, s1_ny_q, s1_nz_q;

  // ---------------- stage 2: cross and dot sums
  logic                 s2_v_q;
  logic signed [CW-1:0] crs_x_q, crs_y_q, crs_z_q;
  logic signed [DW-1:0] s2_dot_q;
  logic signed [CB-1:0] s2_nx_q, s2_ny_q, s2_nz_q;

  // ---------------- stage 3: triple product terms
  logic                  s3_v_q;
  logic signed [TPW-1:0] tp_x_q, tp_y_q, tp_z_q;
  logic signed [DW-1:0]  s3_dot_q;

  // ---------------- stage 4: triple product
  logic                 s4_v_q;
  logic signed [TW-1:0] s4_trip_q;
  logic signed [DW-1:0] s4_dot_q;

  // ---------------- stages 5 to 7: magnitude and normalize
  logic                 s5_v_q, s6_v_q, s7_v_q;
  logic                 s5_zero_q, s6_zero_q, s7_zero_q;
  logic signed [NW-1:0] s5_t_q, s5_d_q, s6_t_q, s6_d_q, s7_t_q, s7_d_q;
  logic        [NW-1:0] s5_m_q, s6_m_q, s7_m_q;
  logic signed [NW-1:0] t5_ext, d5_ext;
  logic        [NW-1:0] t5_abs, d5_abs;
  logic signed [NW-1:0] s6_t_d, s6_d_d, s7_t_d, s7_d_d;
  logic        [NW-1:0] s6_m_d, s7_m_d;

  // ---------------- CORDIC pipeline, index 0 holds the pre-rotated vector
  logic signed [XW-1:0] cord_x_q [CORDIC_STEPS+1];
  logic signed [XW-1:0] cord_y_q [CORDIC_STEPS+1];
  angle_acc_t           cord_z_q [CORDIC_STEPS+1];
  logic                 czero_q  [CORDIC_STEPS+1];
  logic                 cv_q     [CORDIC_STEPS+1];
  logic signed [XW-1:0] pre_x_d, pre_y_d, pre_xe, pre_ye;
  angle_acc_t           pre_z_d;

  // ---------------- output register
  logic                 out_valid_q;
  logic signed [OW-1:0] angle_q, angle_d;
  angle_acc_t           rnd;

  // Hold every stage while the output item waits.
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // ---------------- valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      s4_v_q      <= 1'b0;
      s5_v_q      <= 1'b0;
      s6_v_q      <= 1'b0;
      s7_v_q      <= 1'b0;
      cv_q[0]     <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_v_q      <= in_valid_i;
      s2_v_q      <= s1_v_q;
      s3_v_q      <= s2_v_q;
      s4_v_q      <= s3_v_q;
      s5_v_q      <= s4_v_q;
      s6_v_q      <= s5_v_q;
      s7_v_q      <= s6_v_q;
      cv_q[0]     <= s7_v_q;
      out_valid_q <= cv_q[CORDIC_STEPS];
    end
  end

  // ---------------- stages 1 to 4
  always_ff @(posedge clk_i) begin
    if (en) begin
      p_aybz_q <= PW'(first_y_i) * PW'(second_z_i);
      p_azby_q <= PW'(first_z_i) * PW'(second_y_i);
      p_azbx_q <= PW'(first_z_i) * PW'(second_x_i);
      p_axbz_q <= PW'(first_x_i) * PW'(second_z_i);
      p_axby_q <= PW'(first_x_i) * PW'(second_y_i);
      p_aybx_q <= PW'(first_y_i) * PW'(second_x_i);
      p_axbx_q <= PW'(first_x_i) * PW'(second_x_i);
      p_ayby_q <= PW'(first_y_i) * PW'(second_y_i);
      p_azbz_q <= PW'(first_z_i) * PW'(second_z_i);
      s1_nx_q  <= ref_axis_x_i;
      s1_ny_q  <= ref_axis_y_i;
      s1_nz_q  <= ref_axis_z_i;

      crs_x_q  <= CW'(p_aybz_q) - CW'(p_azby_q);
      crs_y_q  <= CW'(p_azbx_q) - CW'(p_axbz_q);
      crs_z_q  <= CW'(p_axby_q) - CW'(p_aybx_q);
      s2_dot_q <= DW'(p_axbx_q) + DW'(p_ayby_q) + DW'(p_azbz_q);
      s2_nx_q  <= s1_nx_q;
      s2_ny_q  <= s1_ny_q;
      s2_nz_q  <= s1_nz_q;

      tp_x_q   <= TPW'(crs_x_q) * TPW'(s2_nx_q);
      tp_y_q   <= TPW'(crs_y_q) * TPW'(s2_ny_q);
      tp_z_q   <= TPW'(crs_z_q) * TPW'(s2_nz_q);
      s3_dot_q <= s2_dot_q;

      s4_trip_q <= TW'(tp_x_q) + TW'(tp_y_q) + TW'(tp_z_q);
      s4_dot_q  <= s3_dot_q;
    end
  end

  // ---------------- stage 5: magnitudes, OR keeps the leading one of the larger
  always_comb begin
    t5_ext = NW'(s4_trip_q);
    d5_ext = NW'(s4_dot_q);
    t5_abs = t5_ext[NW-1] ? -t5_ext : t5_ext;
    d5_abs = d5_ext[NW-1] ? -d5_ext : d5_ext;
  end

  // ---------------- stages 6 and 7: binary-search left shift up to bit NORM_TOP
  always_comb begin
    s6_t_d = s5_t_q;
    s6_d_d = s5_d_q;
    s6_m_d = s5_m_q;
    for (int j = 0; j < NORM_SPLIT; j++) begin
      if ((s6_m_d >> (NORM_TOP + 1 - (1 << (NORM_STEPS - 1 - j)))) == '0) begin
        s6_t_d = s6_t_d <<< (1 << (NORM_STEPS - 1 - j));
        s6_d_d = s6_d_d <<< (1 << (NORM_STEPS - 1 - j));
        s6_m_d = s6_m_d << (1 << (NORM_STEPS - 1 - j));
      end
    end
  end

  always_comb begin
    s7_t_d = s6_t_q;
    s7_d_d = s6_d_q;
    s7_m_d = s6_m_q;
    for (int j = NORM_SPLIT; j < NORM_STEPS; j++) begin
      if ((s7_m_d >> (NORM_TOP + 1 - (1 << (NORM_STEPS - 1 - j)))) == '0) begin
        s7_t_d = s7_t_d <<< (1 << (NORM_STEPS - 1 - j));
        s7_d_d = s7_d_d <<< (1 << (NORM_STEPS - 1 - j));
        s7_m_d = s7_m_d << (1 << (NORM_STEPS - 1 - j));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_t_q    <= t5_ext;
      s5_d_q    <= d5_ext;
      s5_m_q    <= t5_abs | d5_abs;
      s5_zero_q <= (s4_trip_q == '0) && (s4_dot_q == '0);

      s6_t_q    <= s6_t_d;
      s6_d_q    <= s6_d_d;
      s6_m_q    <= s6_m_d;
      s6_zero_q <= s5_zero_q;

      s7_t_q    <= s7_t_d;
      s7_d_q    <= s7_d_d;
      s7_m_q    <= s7_m_d;
      s7_zero_q <= s6_zero_q;
    end
  end

  // ---------------- stage 8: quarter-turn into the right half plane
  always_comb begin
    pre_xe = XW'(s7_d_q);
    pre_ye = XW'(s7_t_q);
    if (pre_xe[XW-1]) begin
      if (!pre_ye[XW-1]) begin
        pre_x_d = pre_ye;
        pre_y_d = -pre_xe;
        pre_z_d = HALF_PI_Q30;
      end else begin
        pre_x_d = -pre_ye;
        pre_y_d = pre_xe;
        pre_z_d = -HALF_PI_Q30;
      end
    end else begin
      pre_x_d = pre_xe;
      pre_y_d = pre_ye;
      pre_z_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cord_x_q[0] <= pre_x_d;
      cord_y_q[0] <= pre_y_d;
      cord_z_q[0] <= pre_z_d;
      czero_q[0]  <= s7_zero_q;
    end
  end

  // ---------------- CORDIC vectoring, one iteration per stage
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    logic signed [XW-1:0] xs, ys, x_d, y_d;
    angle_acc_t           z_d;

    always_comb begin
      xs = cord_x_q[i] >>> i;
      ys = cord_y_q[i] >>> i;
      if (!cord_y_q[i][XW-1]) begin
        x_d = cord_x_q[i] + ys;
        y_d = cord_y_q[i] - xs;
        z_d = cord_z_q[i] + atan_q30(i);
      end else begin
        x_d = cord_x_q[i] - ys;
        y_d = cord_y_q[i] + xs;
        z_d = cord_z_q[i] - atan_q30(i);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[i+1] <= 1'b0;
      end else if (en) begin
        cv_q[i+1] <= cv_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        cord_x_q[i+1] <= x_d;
        cord_y_q[i+1] <= y_d;
        cord_z_q[i+1] <= z_d;
        czero_q[i+1]  <= czero_q[i];
      end
    end
  end

  // ---------------- round half up, saturate to +-pi, force zero for a null item
  always_comb begin
    rnd = (cord_z_q[CORDIC_STEPS] + HALF_RND) >>> SH;
    if (rnd > LIM) begin
      rnd = LIM;
    end else if (rnd < -LIM) begin
      rnd = -LIM;
    end
    angle_d = czero_q[CORDIC_STEPS] ? '0 : OW'(rnd);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      angle_q <= angle_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign signed_angle_o = angle_q;

  // ---------------- assertions
  a_angle_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (signed_angle_o <= LIM_O) && (signed_angle_o >= -LIM_O))
    else $error("angle beyond +-pi");

  a_null_item_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && cv_q[CORDIC_STEPS] && czero_q[CORDIC_STEPS] |=> signed_angle_o == '0)
    else $error("null item gave a nonzero angle");

  a_normalized: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s7_v_q && !s7_zero_q |-> (s7_m_q >> NORM_TOP) != '0)
    else $error("normalize stage left magnitude below threshold");

endmodule
